### rtl/core/taylor_series_exponential_assert.svh
// Assertion macros for the exponential series block.
// Included by the checker; no other dependencies.
`ifndef TAYLOR_SERIES_EXPONENTIAL_ASSERT_SVH
`define TAYLOR_SERIES_EXPONENTIAL_ASSERT_SVH

// Property that is checked only while reset is released.
`define TSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Property that is checked at every edge, reset included.
`define TSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/tse_pkg.sv
// Shared types and constants of the exponential series block.
// No dependencies; used by the core and the checker.
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int FLOOR_W    = 24;

    // Register index decode (byte address bits above the word offset).
    localparam logic [APB_ADDR_W-3:0] REG_PRECISION_FLOOR = 1'b0;

    // Magnitude limits of a term: the largest positive and negative 64-bit values.
    localparam logic [63:0] MAG_LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_LIM_NEG = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic        [5:0]  term_count;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] exp_value;
        logic               overflowed;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/core/tse_stream_if.sv
// Valid/ready stream channel that carries one item payload.
// The payload type is set per instance; see tse_pkg for the item types.
`timescale 1ns / 1ps
`default_nettype none

interface tse_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/tse_div.sv
// Iterative unsigned divider by a small integer, eight quotient bits per cycle.
// Used by taylor_series_exponential; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tse_div #(
    parameter int DIV_W = 72,
    parameter int K_W   = 6,
    parameter int Q_W   = 72
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [K_W-1:0]   i_divisor,
    output logic                  o_done,
    output logic [Q_W-1:0]        o_quotient
);

    localparam int STEPS  = 8;
    localparam int CYCLES = DIV_W / STEPS;
    localparam int CNT_W  = $clog2(CYCLES + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [K_W-1:0]   r_rem;
    logic [K_W-1:0]   r_divisor;
    logic [Q_W-1:0]   r_quo;

    logic [DIV_W-1:0] n_num;
    logic [K_W-1:0]   n_rem;
    logic [STEPS-1:0] n_qbits;

    // Restoring division: the remainder stays below the divisor, so each trial
    // value fits in one bit more than the divisor.
    always_comb begin
        logic [K_W:0] trial;
        n_rem   = r_rem;
        n_num   = r_num;
        n_qbits = '0;
        for (int i = 0; i < STEPS; i++) begin
            trial = {n_rem, n_num[DIV_W-1]};
            n_num = n_num << 1;
            if (trial >= {1'b0, r_divisor}) begin
                n_rem               = K_W'(trial - {1'b0, r_divisor});
                n_qbits[STEPS-1-i] = 1'b1;
            end else begin
                n_rem = trial[K_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(CYCLES);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_quo     <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= {r_quo[Q_W-STEPS-1:0], n_qbits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### rtl/core/taylor_series_exponential.sv
// Fixed-point e^x by Taylor partial sum, computed one term at a time.
// Depends on tse_pkg, tse_stream_if and tse_div.
//
// Usage: an item on i_in carries x_value (signed Q7.24) and term_count. One
// result item on o_out carries exp_value (signed Q39.24) and overflowed.
// The APB port holds precision_floor at byte address 0 (pready is always high);
// write it only while the block is idle.
// Each term k takes two passes through one shared 32x32 multiplier, a load
// step, a divider pass by k (eight quotient bits per cycle) and a wait to see
// the divider finish, a term clamp, a saturating add and a floor/count check.
// The result is registered once the series ends and the output register is
// free, and the next item can be taken in the cycle after that. The series
// runs for the clamped term count, fewer if the floor stops it.
// i_in.ready is high only while the sequencer is idle; one item is worked at a
// time. A finished result sits in the output register until taken, and the next
// item may be accepted meanwhile; its result then waits until o_out frees up.
// Reset empties the output register, returns the sequencer to idle and clears
// precision_floor.
`timescale 1ns / 1ps
`default_nettype none

module taylor_series_exponential #(
    parameter int MAX_TERMS = 63,
    parameter int FRAC_BITS = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    tse_stream_if.sink                           i_in,
    tse_stream_if.source                         o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tse_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tse_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tse_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int KW     = $clog2(MAX_TERMS + 1);
    localparam int NW     = (KW > 6) ? KW : 6;
    localparam int PROD_W = 95;
    localparam int DW     = ((PROD_W - FRAC_BITS + 7) / 8) * 8;
    localparam int QW     = (DW > 64) ? DW : 65;
    localparam int FL_SHL = (FRAC_BITS >= 24) ? (FRAC_BITS - 24) : 0;
    localparam int FL_SHR = (FRAC_BITS < 24) ? (24 - FRAC_BITS) : 0;
    localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b0_0000_0001,
        S_CHECK  = 9'b0_0000_0010,
        S_MUL_LO = 9'b0_0000_0100,
        S_MUL_HI = 9'b0_0000_1000,
        S_LOAD   = 9'b0_0001_0000,
        S_DIV    = 9'b0_0010_0000,
        S_TERM   = 9'b0_0100_0000,
        S_ADD    = 9'b0_1000_0000,
        S_DONE   = 9'b1_0000_0000
    } t_state;

    t_state                    r_state, n_state;
    logic [tse_pkg::FLOOR_W-1:0] r_floor;
    logic [31:0]               r_xmag, n_xmag;
    logic                      r_xneg, n_xneg;
    logic [KW-1:0]             r_n, n_n;
    logic [KW:0]               r_k, n_k;
    logic [63:0]               r_sum, n_sum;
    logic [63:0]               r_tmag, n_tmag;
    logic                      r_tneg, n_tneg;
    logic                      r_ovf, n_ovf;
    logic [63:0]               r_lo, r_hi;
    tse_pkg::t_out_item        r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic [31:0]     mul_a;
    logic [63:0]     mul_p;
    logic [PROD_W:0] prod_full;
    logic [DW-1:0]   div_dividend;
    logic            div_start;
    logic            div_done;
    logic [QW-1:0]   div_quo;
    logic [63:0]     floor_fx;
    logic            cfg_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[tse_pkg::APB_ADDR_W-1:2] == tse_pkg::REG_PRECISION_FLOOR);
    assign prdata = (paddr[tse_pkg::APB_ADDR_W-1:2] == tse_pkg::REG_PRECISION_FLOOR)
                  ? tse_pkg::APB_DATA_W'(r_floor) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= '0;
        end else if (cfg_wr) begin
            r_floor <= pwdata[tse_pkg::FLOOR_W-1:0];
        end
    end

    assign floor_fx = (64'(r_floor) << FL_SHL) >> FL_SHR;

    // Shared multiplier: low then high half of the term magnitude times |x|.
    assign mul_a = (r_state == S_MUL_HI) ? r_tmag[63:32] : r_tmag[31:0];
    assign mul_p = {32'd0, mul_a} * {32'd0, r_xmag};

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL_LO) begin
            r_lo <= mul_p;
        end
        if (r_state == S_MUL_HI) begin
            r_hi <= mul_p;
        end
    end

    // The product stays below 2^95, so the truncation drops only zero bits.
    assign prod_full    = {r_hi, 32'd0} + {32'd0, r_lo};
    assign div_dividend = DW'(prod_full >> FRAC_BITS);
    assign div_start    = (r_state == S_LOAD);

    tse_div #(
        .DIV_W (DW),
        .K_W   (KW),
        .Q_W   (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_k[KW-1:0]),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        logic [NW-1:0] tc_ext;
        logic [63:0]   smag;
        logic [63:0]   q64;
        logic          big;
        logic          tneg_new;
        logic [63:0]   lim;
        logic [63:0]   tv;
        logic [63:0]   sum_new;

        n_state     = r_state;
        n_xmag      = r_xmag;
        n_xneg      = r_xneg;
        n_n         = r_n;
        n_k         = r_k;
        n_sum       = r_sum;
        n_tmag      = r_tmag;
        n_tneg      = r_tneg;
        n_ovf       = r_ovf;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        tc_ext   = NW'(i_in.payload.term_count);
        smag     = r_sum[63] ? (~r_sum + 64'd1) : r_sum;
        q64      = div_quo[63:0];
        big      = |div_quo[QW-1:64];
        tneg_new = ((q64 != 64'd0) || big) ? (r_tneg ^ r_xneg) : 1'b0;
        lim      = tneg_new ? tse_pkg::MAG_LIM_NEG : tse_pkg::MAG_LIM_POS;
        tv       = r_tneg ? (~r_tmag + 64'd1) : r_tmag;
        sum_new  = r_sum + tv;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_xneg = i_in.payload.x_value[31];
                    n_xmag = i_in.payload.x_value[31]
                           ? (~i_in.payload.x_value + 32'd1) : i_in.payload.x_value;
                    n_n    = (tc_ext > NW'(MAX_TERMS)) ? KW'(MAX_TERMS) : KW'(tc_ext);
                    n_k    = (KW + 1)'(1);
                    n_sum  = ONE_FX;
                    n_tmag = ONE_FX;
                    n_tneg = 1'b0;
                    n_ovf  = 1'b0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((r_k > {1'b0, r_n}) || (smag < floor_fx)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_LOAD;
            S_LOAD:   n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                n_tneg = tneg_new;
                if (big || (q64 > lim)) begin
                    n_tmag = lim;
                    n_ovf  = 1'b1;
                end else begin
                    n_tmag = q64;
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                // Same-sign operands whose sum flips sign have overflowed.
                if ((r_sum[63] == tv[63]) && (sum_new[63] != r_sum[63])) begin
                    n_sum = r_sum[63] ? tse_pkg::MAG_LIM_NEG : tse_pkg::MAG_LIM_POS;
                    n_ovf = 1'b1;
                end else begin
                    n_sum = sum_new;
                end
                n_k     = r_k + 1'b1;
                n_state = S_CHECK;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out.exp_value  = r_sum;
                    n_out.overflowed = r_ovf;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xmag <= n_xmag;
        r_xneg <= n_xneg;
        r_n    <= n_n;
        r_k    <= n_k;
        r_sum  <= n_sum;
        r_tmag <= n_tmag;
        r_tneg <= n_tneg;
        r_ovf  <= n_ovf;
        r_out  <= n_out;
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

### rtl/core/tse_checker.sv
// Port-level checks for taylor_series_exponential, bound to the top level.
// Depends on tse_pkg and taylor_series_exponential_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "taylor_series_exponential_assert.svh"

module tse_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [$bits(tse_pkg::t_out_item)-1:0] i_out_payload,
    input wire logic                                i_pready
);

    `TSE_ASSERT_ALWAYS(a_pready_high, i_clk, i_pready, "pready dropped")

    `TSE_ASSERT_ALWAYS(a_reset_empties_output, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // The sequencer leaves idle on an accepted item, so it cannot take another at once.
    `TSE_ASSERT(a_one_item_at_a_time, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "input taken twice in a row")

    `TSE_ASSERT(a_stalled_result_holds, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)), "stalled result changed")

endmodule

bind taylor_series_exponential tse_checker u_tse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload),
    .i_pready      (pready)
);

`default_nettype wire
